### hdl/cdg_pkg.sv
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared types and constants of the subcode graphics decoder.
// ----------------------------------------------------------------------------
package cdg_pkg;

	localparam logic [5:0] CMD_CDG        = 6'h09;
	localparam logic [5:0] INS_MEM_PRESET = 6'd1;
	localparam logic [5:0] INS_BRD_PRESET = 6'd2;
	localparam logic [5:0] INS_TILE       = 6'd6;
	localparam logic [5:0] INS_TILE_XOR   = 6'd38;
	localparam logic [5:0] INS_PAL_LOW    = 6'd30;
	localparam logic [5:0] INS_PAL_HIGH   = 6'd31;

	typedef enum logic [2:0] {
		OP_READ,
		OP_MEM,
		OP_BRD,
		OP_TILE,
		OP_TXOR,
		OP_PAL
	} op_t;

	// classified work item passed from front to back
	typedef struct packed {
		op_t          op;
		logic [3:0]   color0;
		logic [3:0]   color1;
		logic [4:0]   row;
		logic [5:0]   col;
		logic         pal_high;
		logic [127:0] data;
		logic [8:0]   rx;
		logic [7:0]   ry;
	} cmd_t;

	// 4-bit channel times 17 packed to rgb565
	function automatic logic [15:0] pal_pack(input logic [7:0] a, input logic [7:0] b);
		logic [3:0] r4;
		logic [3:0] g4;
		logic [3:0] b4;
		r4 = a[5:2];
		g4 = {a[1:0], b[5:4]};
		b4 = b[3:0];
		pal_pack = {r4, r4[3], g4, g4[3:2], b4, b4[3]};
	endfunction

endpackage

### hdl/cdg_stream_if.sv
// ----------------------------------------------------------------------------
// cdg_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface cdg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/cdg_ram.sv
// ----------------------------------------------------------------------------
// cdg_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdg_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 76800
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/cdg_front.sv
// ----------------------------------------------------------------------------
// cdg_front
// Accepts input words, decodes them and pushes work into a small queue.
// ----------------------------------------------------------------------------
module cdg_front
	import cdg_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   kind,
	input  logic [7:0]   command,
	input  logic [7:0]   instruction,
	input  logic [63:0]  data_low,
	input  logic [63:0]  data_high,
	input  logic [8:0]   read_x,
	input  logic [7:0]   read_y,
	output logic   cmd_valid,
	input  logic   cmd_ready,
	output cmd_t   cmd
);
	localparam int DEPTH = 2;
	localparam logic [8:0] X_MAX = 9'(SCREEN_WIDTH - 1);
	localparam logic [7:0] Y_MAX = 8'(SCREEN_HEIGHT - 1);

	cmd_t       fifo_q [DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       keep;
	logic [5:0] ins;
	logic       push;
	logic       pop;

	assign ins = instruction[5:0];

	// classify the incoming word
	always_comb begin
		dec          = '0;
		dec.data     = {data_high, data_low};
		dec.color0   = data_low[3:0];
		dec.color1   = data_low[11:8];
		dec.row      = data_low[20:16];
		dec.col      = data_low[29:24];
		dec.pal_high = ins[0];
		dec.rx       = (read_x > X_MAX) ? X_MAX : read_x;
		dec.ry       = (read_y > Y_MAX) ? Y_MAX : read_y;
		keep         = 1'b0;
		dec.op       = OP_READ;
		if (kind) begin
			keep = 1'b1;
		end else if (command[5:0] == CMD_CDG) begin
			case (ins)
				INS_MEM_PRESET: begin
					dec.op = OP_MEM;
					keep   = (data_low[13:8] == 6'd0);
				end
				INS_BRD_PRESET: begin
					dec.op = OP_BRD;
					keep   = 1'b1;
				end
				INS_TILE, INS_TILE_XOR: begin
					dec.op = (ins == INS_TILE) ? OP_TILE : OP_TXOR;
					keep   = (data_low[20:16] <= 5'd17) && (data_low[29:24] <= 6'd49);
				end
				INS_PAL_LOW, INS_PAL_HIGH: begin
					dec.op = OP_PAL;
					keep   = 1'b1;
				end
				default: keep = 1'b0;
			endcase
		end
	end

	assign in_ready  = (cnt_q != 2'(DEPTH));
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### hdl/cdg_back.sv
// ----------------------------------------------------------------------------
// cdg_back
// Executes queued work on the frame store and palette, returns read words.
// ----------------------------------------------------------------------------
module cdg_back
	import cdg_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  pixel_index,
	output logic [15:0] pixel_rgb
);
	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW   = $clog2(NPIX);
	localparam int XW   = $clog2(SCREEN_WIDTH);
	localparam int YW   = $clog2(SCREEN_HEIGHT);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FILL, S_PAL, S_TRD, S_TWAIT, S_TWR, S_RWAIT, S_RDATA, S_OUT
	} state_t;

	state_t         state_q;
	cmd_t           cur_q;
	logic [XW-1:0]  x_q;
	logic [YW-1:0]  y_q;
	logic [AW-1:0]  clr_q;
	logic [2:0]     m_q;
	logic [3:0]     k_q;
	logic [15:0]    pal_q [16];
	logic [3:0]     idx_q;
	logic [15:0]    rgb_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [3:0]     wdata;
	logic [AW-1:0]  raddr;
	logic [3:0]     rdata;
	logic [AW-1:0]  xy_addr;
	logic [XW-1:0]  tx;
	logic [YW-1:0]  ty;
	logic           tbit;
	logic [3:0]     tcol;
	logic [7:0]     tbyte;
	logic           border;
	logic [XW-1:0]  fx0;
	logic [XW-1:0]  fx1;
	logic [YW-1:0]  fy1;

	cdg_ram #(.WIDTH(4), .DEPTH(NPIX)) u_frame (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// tile pixel position and source color
	assign tx    = XW'(cur_q.col * 6 + 10) + XW'(m_q);
	assign ty    = YW'(cur_q.row * 12 + 12) + YW'(k_q);
	assign tbyte = cur_q.data[8*(32'(k_q)+4) +: 8];
	assign tbit  = tbyte[3'd5 - m_q];
	assign tcol  = tbit ? cur_q.color1 : cur_q.color0;

	// sweep bounds for presets
	assign fx0 = (cur_q.op == OP_MEM) ? XW'(10) : XW'(0);
	assign fx1 = (cur_q.op == OP_MEM) ? XW'(SCREEN_WIDTH - 11) : XW'(SCREEN_WIDTH - 1);
	assign fy1 = (cur_q.op == OP_MEM) ? YW'(SCREEN_HEIGHT - 13) : YW'(SCREEN_HEIGHT - 1);
	assign border = (y_q < YW'(12)) || (y_q > YW'(SCREEN_HEIGHT - 13))
		|| (x_q < XW'(10)) || (x_q > XW'(SCREEN_WIDTH - 11));

	// address of current x/y
	assign xy_addr = AW'(32'(y_q) * SCREEN_WIDTH) + AW'(x_q);

	// frame write and read port control
	always_comb begin
		we    = 1'b0;
		waddr = xy_addr;
		wdata = cur_q.color0;
		raddr = xy_addr;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 4'd0;
			end
			S_FILL: we = (cur_q.op == OP_MEM) || border;
			S_TWR: begin
				we    = 1'b1;
				wdata = (cur_q.op == OP_TXOR) ? (tcol ^ rdata) : tcol;
			end
			default: we = 1'b0;
		endcase
	end

	assign cmd_ready   = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign pixel_index = idx_q;
	assign pixel_rgb   = rgb_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_q   <= '0;
			clr_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
			idx_q   <= '0;
			rgb_q   <= '0;
			for (int i = 0; i < 16; i++) pal_q[i] <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NPIX - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q <= cmd;
						case (cmd.op)
							OP_READ: begin
								x_q     <= cmd.rx;
								y_q     <= cmd.ry;
								state_q <= S_RWAIT;
							end
							OP_MEM: begin
								x_q     <= XW'(10);
								y_q     <= YW'(12);
								state_q <= S_FILL;
							end
							OP_BRD: begin
								x_q     <= '0;
								y_q     <= '0;
								state_q <= S_FILL;
							end
							OP_PAL: state_q <= S_PAL;
							default: begin
								m_q     <= '0;
								k_q     <= '0;
								state_q <= S_TRD;
							end
						endcase
					end
				end
				S_FILL: begin
					if (x_q == fx1) begin
						x_q <= fx0;
						if (y_q == fy1) state_q <= S_IDLE;
						else y_q <= y_q + YW'(1);
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				S_PAL: begin
					for (int i = 0; i < 8; i++) begin
						pal_q[{cur_q.pal_high, 3'(i)}] <=
							pal_pack(cur_q.data[16*i +: 8], cur_q.data[16*i+8 +: 8]);
					end
					state_q <= S_IDLE;
				end
				S_TRD: begin
					x_q     <= tx;
					y_q     <= ty;
					state_q <= S_TWAIT;
				end
				S_TWAIT: state_q <= S_TWR;
				S_TWR: begin
					if (m_q == 3'd5) begin
						m_q <= '0;
						if (k_q == 4'd11) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= S_TRD;
						end
					end else begin
						m_q     <= m_q + 3'd1;
						state_q <= S_TRD;
					end
				end
				S_RWAIT: state_q <= S_RDATA;
				S_RDATA: begin
					idx_q   <= rdata;
					rgb_q   <= pal_q[rdata];
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/cdg_subcode_graphics_decoder_core.sv
// ----------------------------------------------------------------------------
// cdg_subcode_graphics_decoder_core
// CD+G decoder: frame index store, palette, and pixel readback.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_if   | in  | kind, command, instruction, data_low, data_high, read_x, read_y
//  out_if  | out | pixel_index, pixel_rgb
//
// After reset a clearing pass writes all 76800 frame entries, one a cycle;
// items queue in the front but nothing executes until it ends.
// Tiles step through read, wait and write states for each of their 72 pixels.
// Presets take one cycle per swept pixel (64800 or 76800); reads pass wait, data, output.
// The front queue holds two items; the back stalls while a result waits.
module cdg_subcode_graphics_decoder_core
	import cdg_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input logic clk,
	input logic arst_n,
	cdg_stream_if.sink   in_if,
	cdg_stream_if.source out_if
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	cdg_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_if.valid), .in_ready(in_if.ready),
		.kind(in_if.payload.kind), .command(in_if.payload.command),
		.instruction(in_if.payload.instruction),
		.data_low(in_if.payload.data_low), .data_high(in_if.payload.data_high),
		.read_x(in_if.payload.read_x), .read_y(in_if.payload.read_y),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	cdg_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_if.valid), .out_ready(out_if.ready),
		.pixel_index(out_if.payload.pixel_index), .pixel_rgb(out_if.payload.pixel_rgb)
	);
endmodule

### bench/tb_cdg_subcode_graphics_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cdg_subcode_graphics_decoder_core
// Drives subcode packets and pixel reads into the decoder and checks every
// read word against a frame and palette kept in the bench. Directed packets
// cover each operation and corner case, then random traffic runs under
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_cdg_subcode_graphics_decoder_core;
	import cdg_pkg::*;

	localparam int WIDTH  = 320;
	localparam int HEIGHT = 240;
	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct packed {
		logic        kind;
		logic [7:0]  command;
		logic [7:0]  instruction;
		logic [63:0] data_low;
		logic [63:0] data_high;
		logic [8:0]  read_x;
		logic [7:0]  read_y;
	} packet_word_t;

	typedef struct packed {
		logic [3:0]  pixel_index;
		logic [15:0] pixel_rgb;
	} pixel_word_t;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	logic clk;
	logic arst_n;

	cdg_stream_if #(.payload_t(packet_word_t)) in_if ();
	cdg_stream_if #(.payload_t(pixel_word_t))  out_if ();

	cdg_subcode_graphics_decoder_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_if (in_if),
		.out_if(out_if)
	);

	// bench copy of the decoder state
	logic [3:0]  frame_idx [WIDTH*HEIGHT];
	logic [15:0] palette [16];
	pixel_word_t pixel_q [$];

	int  fail_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_cycles;
	int  quiet_cycles;
	int  last_col;
	int  last_row;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// --------------------------------------------------------------------
	// prediction
	// --------------------------------------------------------------------
	function automatic logic [7:0] pkt_byte(packet_word_t w, int i);
		logic [127:0] d;
		d = {w.data_high, w.data_low};
		return d[8*i +: 8];
	endfunction

	function automatic logic [15:0] rgb565(logic [7:0] a, logic [7:0] b);
		int r;
		int g;
		int bl;
		r  = ((a & 8'h3F) >> 2) * 17;
		g  = (((a & 3) << 2) | ((b & 8'h3F) >> 4)) * 17;
		bl = (b & 15) * 17;
		return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((bl & 'hF8) >> 3));
	endfunction

	task automatic fill_area(int x0, int x1, int y0, int y1, logic [3:0] c);
		for (int y = y0; y < y1; y++)
			for (int x = x0; x < x1; x++)
				frame_idx[y*WIDTH + x] = c;
	endtask

	task automatic apply_word(packet_word_t w);
		logic [3:0]  c0;
		logic [3:0]  c1;
		logic [3:0]  c;
		logic [7:0]  line;
		logic [5:0]  op;
		int x;
		int y;
		int row;
		int col;
		pixel_word_t res;
		if (w.kind == KIND_READ) begin
			x = (int'(w.read_x) > WIDTH-1) ? WIDTH-1 : int'(w.read_x);
			y = (int'(w.read_y) > HEIGHT-1) ? HEIGHT-1 : int'(w.read_y);
			res.pixel_index = frame_idx[y*WIDTH + x];
			res.pixel_rgb = palette[res.pixel_index];
			pixel_q.push_back(res);
			return;
		end
		if (w.command[5:0] != CMD_CDG)
			return;
		c0 = 4'(pkt_byte(w, 0));
		c1 = 4'(pkt_byte(w, 1));
		op = w.instruction[5:0];
		case (op)
			INS_MEM_PRESET: begin
				if ((pkt_byte(w, 1) & 8'h3F) == 0)
					fill_area(10, 310, 12, 228, c0);
			end
			INS_BRD_PRESET: begin
				fill_area(0, WIDTH, 0, 12, c0);
				fill_area(0, WIDTH, 228, HEIGHT, c0);
				fill_area(0, 10, 12, 228, c0);
				fill_area(310, WIDTH, 12, 228, c0);
			end
			INS_TILE, INS_TILE_XOR: begin
				row = int'(pkt_byte(w, 2) & 8'h1F);
				col = int'(pkt_byte(w, 3) & 8'h3F);
				if (row <= 17 && col <= 49) begin
					for (int k = 0; k < 12; k++) begin
						line = pkt_byte(w, 4 + k);
						for (int m = 0; m < 6; m++) begin
							c = line[5-m] ? c1 : c0;
							x = col*6 + 10 + m;
							y = row*12 + 12 + k;
							if (op == INS_TILE_XOR)
								c = c ^ frame_idx[y*WIDTH + x];
							frame_idx[y*WIDTH + x] = c;
						end
					end
				end
			end
			INS_PAL_LOW, INS_PAL_HIGH: begin
				for (int i = 0; i < 8; i++)
					palette[(op == INS_PAL_HIGH ? 8 : 0) + i] =
						rgb565(pkt_byte(w, 2*i), pkt_byte(w, 2*i + 1));
			end
			default: ;
		endcase
	endtask

	// --------------------------------------------------------------------
	// word builders
	// --------------------------------------------------------------------
	function automatic packet_word_t noise_word();
		packet_word_t w;
		w.kind        = KIND_PACKET;
		w.command     = 8'($urandom);
		w.instruction = 8'($urandom);
		w.data_low    = {$urandom, $urandom};
		w.data_high   = {$urandom, $urandom};
		w.read_x      = 9'($urandom);
		w.read_y      = 8'($urandom);
		return w;
	endfunction

	function automatic packet_word_t cdg_word(logic [5:0] op);
		packet_word_t w;
		w = noise_word();
		w.command     = {2'($urandom), CMD_CDG};
		w.instruction = {2'($urandom), op};
		return w;
	endfunction

	function automatic packet_word_t tile_word(logic [5:0] op, int row, int col);
		packet_word_t w;
		w = cdg_word(op);
		w.data_low[23:16] = {3'($urandom), 5'(row)};
		w.data_low[31:24] = {2'($urandom), 6'(col)};
		return w;
	endfunction

	function automatic packet_word_t read_word(int x, int y);
		packet_word_t w;
		w = noise_word();
		w.kind   = KIND_READ;
		w.read_x = 9'(x);
		w.read_y = 8'(y);
		return w;
	endfunction

	// --------------------------------------------------------------------
	// input driver: one word per call, valid stays high between back-to-back words
	// --------------------------------------------------------------------
	task automatic send_word(packet_word_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_if.valid   <= 1'b1;
		in_if.payload <= w;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		apply_word(w);
		if (w.kind == KIND_PACKET && w.command[5:0] == CMD_CDG &&
				(w.instruction[5:0] == INS_TILE || w.instruction[5:0] == INS_TILE_XOR)) begin
			last_row = int'(w.data_low[20:16]);
			last_col = int'(w.data_low[29:24]);
		end
	endtask

	task automatic idle_input();
		in_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pixel_q.size() != 0) @(posedge clk);
	endtask

	// output ready: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles  <= hold_cycles - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected word index=%0d rgb=%h", $time,
					out_if.payload.pixel_index, out_if.payload.pixel_rgb);
				fail_count++;
			end else begin
				want = pixel_q.pop_front();
				if (out_if.payload.pixel_index !== want.pixel_index) begin
					$display("%0t: pixel_index expected %0d actual %0d", $time,
						want.pixel_index, out_if.payload.pixel_index);
					fail_count++;
				end
				if (out_if.payload.pixel_rgb !== want.pixel_rgb) begin
					$display("%0t: pixel_rgb expected %h actual %h", $time,
						want.pixel_rgb, out_if.payload.pixel_rgb);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// tests
	// --------------------------------------------------------------------
	task automatic test_reset_state();
		send_word(read_word(0, 0));
		send_word(read_word(511, 255));
	endtask

	task automatic test_palette();
		packet_word_t w;
		w = cdg_word(INS_PAL_LOW);
		w.data_low  = '1;
		w.data_high = 64'h0123_4567_89AB_CDEF;
		send_word(w);
		w = cdg_word(INS_PAL_HIGH);
		w.data_low  = '0;
		send_word(w);
	endtask

	task automatic test_tiles();
		send_word(tile_word(INS_TILE, 0, 0));
		send_word(read_word(10, 12));
		send_word(read_word(15, 23));
		send_word(tile_word(INS_TILE_XOR, 0, 0));
		send_word(read_word(12, 15));
		send_word(tile_word(INS_TILE, 17, 49));
		send_word(read_word(309, 227));
		// off-screen tiles leave the frame alone
		send_word(tile_word(INS_TILE, 18, 0));
		send_word(tile_word(INS_TILE_XOR, 0, 50));
		send_word(read_word(10, 228));
	endtask

	task automatic test_presets();
		packet_word_t w;
		w = cdg_word(INS_MEM_PRESET);
		w.data_low[13:8] = 6'd0;
		send_word(w);
		w = cdg_word(INS_MEM_PRESET);
		w.data_low[13:8] = 6'd5;
		send_word(w);
		send_word(read_word(200, 100));
		send_word(cdg_word(INS_BRD_PRESET));
		send_word(read_word(0, 0));
		send_word(read_word(319, 239));
	endtask

	task automatic test_ignored();
		packet_word_t w;
		w = cdg_word(INS_TILE);
		w.command = 8'hC8;
		send_word(w);
		send_word(cdg_word(6'd63));
		send_word(read_word(20, 20));
	endtask

	// long output hold-off while reads keep coming, then a full drain pause
	task automatic test_backpressure();
		idle_input();
		hold_cycles = 3000;
		repeat (12) send_word(read_word($urandom_range(319), $urandom_range(239)));
		idle_input();
		wait_drained();
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(int count, int idle_pct, int stall_pct);
		int sel;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(999);
			if (sel < 3)
				send_word(cdg_word(sel == 0 ? INS_BRD_PRESET : INS_MEM_PRESET));
			else if (sel < 330)
				send_word(tile_word($urandom_range(1) ? INS_TILE : INS_TILE_XOR,
					($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(17),
					($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(49)));
			else if (sel < 410)
				send_word(cdg_word($urandom_range(1) ? INS_PAL_LOW : INS_PAL_HIGH));
			else if (sel < 440)
				send_word(noise_word());
			else if (sel < 800)
				send_word(read_word(last_col*6 + 10 + $urandom_range(5),
					last_row*12 + 12 + $urandom_range(11)));
			else
				send_word(read_word($urandom_range(511), $urandom_range(255)));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_if.valid    = 1'b0;
		in_if.payload  = '0;
		out_if.ready   = 1'b0;
		fail_count     = 0;
		hold_cycles    = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		last_col       = 0;
		last_row       = 0;
		foreach (frame_idx[i]) frame_idx[i] = '0;
		foreach (palette[i]) palette[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_palette();
		test_tiles();
		test_presets();
		test_ignored();
		test_backpressure();
		random_phase(375, 0, 0);
		random_phase(375, 55, 0);
		random_phase(375, 0, 55);
		random_phase(375, 15, 15);
		idle_input();

		wait_drained();
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
